// ----- rtl/core/phfi_pkg.sv -----
// shared types and constants for the peak hold fade intensity block
`default_nettype none

package phfi_pkg;

  // field widths
  localparam int LEVEL_W     = 13;
  localparam int GROUP_W     = 4;
  localparam int PEAK_W      = 12;
  localparam int STEP_W      = 13;
  localparam int INTENSITY_W = 13;

  // stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  // level conditioning
  localparam int LEVEL_CLAMP = 4094;
  localparam int LEVEL_FLOOR = 1000;
  localparam int LEVEL_SPAN  = 4095;
  localparam int SPAN_LOG    = 12;

  // one step of the sequencer per field, at most one high at a time
  typedef struct packed {
    logic capture;
    logic update;
    logic scale;
    logic atten;
    logic divide;
    logic emit;
  } phfi_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/phfi_ctrl.sv -----
// sequencer for one request at a time through the datapath
`default_nettype none

module phfi_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  output phfi_pkg::phfi_cmd_t cmd
);
  import phfi_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_SCALE,
    S_ATTEN,
    S_DIVIDE,
    S_EMIT
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd         = '0;
    cmd.capture = s_tvalid && s_tready;
    cmd.update  = (state == S_UPDATE);
    cmd.scale   = (state == S_SCALE);
    cmd.atten   = (state == S_ATTEN);
    cmd.divide  = (state == S_DIVIDE);
    cmd.emit    = (state == S_EMIT) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      s_tready <= 1'b1;
      m_tvalid <= 1'b0;
    end else begin
      // a new result replaces the one taken at this edge
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            state    <= S_UPDATE;
            s_tready <= 1'b0;
          end
        end
        S_UPDATE: state <= S_SCALE;
        S_SCALE:  state <= S_ATTEN;
        S_ATTEN:  state <= S_DIVIDE;
        S_DIVIDE: state <= S_EMIT;
        S_EMIT: begin
          // wait here until the output register is free
          if (out_free) begin
            state    <= S_IDLE;
            s_tready <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready == (state == S_IDLE))
    else $error("ready out of step with idle state");

  a_accept_next: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == S_UPDATE && !s_tready))
    else $error("accepted request did not start update");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (m_tvalid && state == S_IDLE))
    else $error("emitted result not offered");

  a_cmd_single: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.capture, cmd.update, cmd.scale, cmd.atten, cmd.divide, cmd.emit}))
    else $error("more than one datapath command");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/phfi_datapath.sv -----
// group state memory, fade update and intensity arithmetic
`default_nettype none

module phfi_datapath #(
  parameter int GROUPS     = 16,
  parameter int FULL_SCALE = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  phfi_pkg::phfi_cmd_t                 cmd,
  input  logic [phfi_pkg::LEVEL_W-1:0]        level,
  input  logic [phfi_pkg::GROUP_W-1:0]        group,
  input  logic                                cfg_wen,
  input  logic [phfi_pkg::STEP_W-1:0]         cfg_wdata,
  output logic [phfi_pkg::INTENSITY_W-1:0]    intensity,
  output logic [phfi_pkg::GROUP_W-1:0]        group_out
);
  import phfi_pkg::*;

  localparam int AW  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int FW  = $clog2(FULL_SCALE + 1);
  localparam int SW  = ((FW > STEP_W) ? FW : STEP_W) + 1;
  localparam int MW  = FW + PEAK_W;
  localparam int RW  = (FW > INTENSITY_W) ? FW : INTENSITY_W;

  // level * FULL_SCALE / 4095 as one multiply by a combined reciprocal
  localparam int N1  = PEAK_W + FW;
  localparam int S1  = N1 + SPAN_LOG;
  localparam int C1W = N1 + FW + 1;
  localparam int P1W = PEAK_W + C1W;
  localparam logic [63:0] M1 =
    ((64'd1 << S1) + 64'(LEVEL_SPAN) - 64'd1) / 64'(LEVEL_SPAN);
  localparam logic [63:0] C1_FULL = M1 * 64'(FULL_SCALE);
  localparam logic [C1W-1:0] C1 = C1_FULL[C1W-1:0];

  // product / FULL_SCALE by reciprocal
  localparam int N2  = 2 * FW;
  localparam int L2  = $clog2(FULL_SCALE);
  localparam int S2  = N2 + L2;
  localparam int M2W = N2 + 1;
  localparam int P2W = N2 + M2W;
  localparam logic [63:0] M2_FULL =
    ((64'd1 << S2) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE);
  localparam logic [M2W-1:0] M2 = M2_FULL[M2W-1:0];

  localparam logic [FW-1:0] FS_F = FW'(FULL_SCALE);

  logic [STEP_W-1:0] fade_step;
  logic [GROUPS-1:0] valid_bits;
  logic [MW-1:0]     mem [GROUPS];

  logic [PEAK_W-1:0] lvl_c;
  logic              in_range_c;
  logic [AW-1:0]     addr_c;

  logic [PEAK_W-1:0] lvl_r;
  logic [GROUP_W-1:0] group_r;
  logic              in_range_r;
  logic              rd_hit;
  logic [MW-1:0]     rd_word;

  logic [PEAK_W-1:0] peak_cur;
  logic [FW-1:0]     fade_cur;
  logic [SW-1:0]     fade_sum;
  logic [PEAK_W-1:0] new_peak;
  logic [FW-1:0]     new_fade;
  logic [AW-1:0]     wr_addr;

  logic [PEAK_W-1:0] peak_r;
  logic [FW-1:0]     fade_r;
  logic [FW-1:0]     cur_s;
  logic [FW-1:0]     pk_s;
  logic [N2-1:0]     prod_r;
  logic [FW-1:0]     faded_r;

  logic [PEAK_W-1:0] scale_in;
  logic [P1W-1:0]    scale_prod;
  logic [FW-1:0]     scale_out;
  logic [P2W-1:0]    div_prod;
  logic [FW-1:0]     result;
  logic [RW-1:0]     res_ext;

  // input conditioning: clamp high, zero below the floor
  always_comb begin
    if (level > LEVEL_W'(LEVEL_CLAMP)) begin
      lvl_c = PEAK_W'(LEVEL_CLAMP);
    end else if (level < LEVEL_W'(LEVEL_FLOOR)) begin
      lvl_c = '0;
    end else begin
      lvl_c = level[PEAK_W-1:0];
    end
  end

  assign in_range_c = (32'(group) < 32'(GROUPS));
  assign addr_c     = AW'(group);
  assign wr_addr    = AW'(group_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      fade_step <= '0;
    end else if (cfg_wen) begin
      fade_step <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lvl_r      <= lvl_c;
      group_r    <= group;
      in_range_r <= in_range_c;
      rd_hit     <= in_range_c && valid_bits[addr_c];
      if (in_range_c) begin
        rd_word <= mem[addr_c];
      end
    end
  end

  // entries never written read as peak zero, fade at full scale
  assign peak_cur = rd_hit ? rd_word[PEAK_W-1:0] : '0;
  assign fade_cur = rd_hit ? rd_word[MW-1:PEAK_W] : FS_F;
  assign fade_sum = SW'(fade_cur) + SW'(fade_step);

  always_comb begin
    if (lvl_r >= peak_cur) begin
      new_peak = lvl_r;
      new_fade = '0;
    end else if (fade_sum >= SW'(FULL_SCALE)) begin
      new_peak = lvl_r;
      new_fade = FS_F;
    end else begin
      new_peak = peak_cur;
      new_fade = fade_sum[FW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (cmd.update && in_range_r) begin
      valid_bits[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && in_range_r) begin
      mem[wr_addr] <= {new_fade, new_peak};
    end
  end

  // shared scaling multiplier: current level first, then the peak
  assign scale_in   = cmd.update ? lvl_r : peak_r;
  assign scale_prod = P1W'(scale_in) * P1W'(C1);
  assign scale_out  = scale_prod[S1 +: FW];

  assign div_prod = P2W'(prod_r) * P2W'(M2);

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      peak_r <= new_peak;
      fade_r <= new_fade;
      cur_s  <= scale_out;
    end
    if (cmd.scale) begin
      pk_s <= scale_out;
    end
    if (cmd.atten) begin
      prod_r <= N2'(pk_s) * N2'(FS_F - fade_r);
    end
    if (cmd.divide) begin
      faded_r <= div_prod[S2 +: FW];
    end
  end

  assign result  = (cur_s > faded_r) ? cur_s : faded_r;
  assign res_ext = RW'(result);

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      intensity <= in_range_r ? res_ext[INTENSITY_W-1:0] : '0;
      group_out <= group_r;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/peak_hold_fade_intensity.sv -----
// top level: per-group peak hold with linear fade, stream in and out
// a request is accepted only in idle and is not overlapped with the one before it;
// the sequencer steps update, two scaling multiplies, attenuation multiply, divide
//   and emit, and emit waits until the output register is free
// reset: synchronous rst clears fade_step, group valid bits and handshakes;
//   groups read as peak zero and fade full scale until first updated
`default_nettype none

module peak_hold_fade_intensity #(
  parameter int GROUPS     = 16,
  parameter int FULL_SCALE = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [phfi_pkg::IN_TDATA_W-1:0]      s_tdata,  // level[12:0]
  input  logic [phfi_pkg::GROUP_W-1:0]         s_tuser,  // group[3:0]
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [phfi_pkg::OUT_TDATA_W-1:0]     m_tdata,  // intensity[12:0]
  output logic [phfi_pkg::GROUP_W-1:0]         m_tuser,  // group_out[3:0]
  input  logic                                 cfg_wen,
  input  logic [phfi_pkg::STEP_W-1:0]          cfg_wdata // fade_step
);
  import phfi_pkg::*;

  phfi_cmd_t              cmd;
  logic [INTENSITY_W-1:0] intensity;

  phfi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  phfi_datapath #(
    .GROUPS     (GROUPS),
    .FULL_SCALE (FULL_SCALE)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .level     (s_tdata[LEVEL_W-1:0]),
    .group     (s_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .intensity (intensity),
    .group_out (m_tuser)
  );

  assign m_tdata = {{(OUT_TDATA_W-INTENSITY_W){1'b0}}, intensity};

endmodule

`default_nettype wire
